// ===== src/scn_pkg.sv =====
// ----------------------------------------------------------------------------
// scn_pkg
// shared constants and codes of the spectral nearest reference classifier
// ----------------------------------------------------------------------------
`default_nettype none

package scn_pkg;

    // default sizes of the block
    localparam int DEF_MAX_REFS    = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed by the item format
    localparam int NUM_CHANNELS   = 8;
    localparam int SHARE_BITS     = 16;
    localparam int CLASS_BITS     = 4;
    localparam int INDEX_BITS     = 5;
    localparam int COUNT_BITS     = 6;
    localparam int THRESH_BITS    = 19;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 19;

    // quotient bits of one share, the top bit only marks the saturating case
    localparam int DIV_STEPS = SHARE_BITS + 1;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(8000);

    // item commands
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_REF_COUNT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'b1;

    // class codes with a brightness override
    localparam logic [CLASS_BITS-1:0] CLASS_BLACK = 4'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_WHITE = 4'd1;

endpackage

`default_nettype wire

// ===== src/scn_ram.sv =====
// ----------------------------------------------------------------------------
// scn_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module scn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/scn_div_lane.sv =====
// ----------------------------------------------------------------------------
// scn_div_lane
// one channel share: restoring division of channel * 2^16 by the vector sum
// ----------------------------------------------------------------------------
`default_nettype none

module scn_div_lane #(
    parameter int SAMPLE_BITS = scn_pkg::DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(scn_pkg::NUM_CHANNELS)
) (
    input  wire                              clk,
    input  wire                              start,
    input  wire                              step,
    input  wire [SAMPLE_BITS-1:0]            dividend,
    input  wire [SUM_BITS-1:0]               divisor,
    output logic [scn_pkg::SHARE_BITS-1:0]   share
);

    localparam int QB = scn_pkg::DIV_STEPS;

    logic [SUM_BITS:0] rem_reg;
    logic [SUM_BITS:0] rem_next;
    logic [QB-1:0]     bits_reg;
    logic [QB-1:0]     bits_next;
    logic [QB-1:0]     quo_reg;
    logic [QB-1:0]     quo_next;
    logic [SUM_BITS:0] rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg[SUM_BITS-1:0], bits_reg[QB-1]};
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // channel never exceeds the sum, so quotient bits above 2^16 are zero
            rem_next  = (SUM_BITS+1)'(dividend >> 1);
            bits_next = {dividend[0], {(QB-1){1'b0}}};
            quo_next  = '0;
        end
        else if (step)
        begin
            bits_next = {bits_reg[QB-2:0], 1'b0};
            if (rem_sh >= {1'b0, divisor})
            begin
                rem_next = rem_sh - {1'b0, divisor};
                quo_next = {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
    end

    // a channel holding the whole sum saturates
    assign share = quo_reg[QB-1] ? '1 : quo_reg[QB-2:0];

endmodule

`default_nettype wire

// ===== src/scn_dist_lane.sv =====
// ----------------------------------------------------------------------------
// scn_dist_lane
// squared difference of one measured share and one reference share
// ----------------------------------------------------------------------------
`default_nettype none

module scn_dist_lane (
    input  wire                                clk,
    input  wire [scn_pkg::SHARE_BITS-1:0]      meas_share,
    input  wire [scn_pkg::SHARE_BITS-1:0]      ref_share,
    output logic [2*scn_pkg::SHARE_BITS-1:0]   sq_reg
);

    logic [scn_pkg::SHARE_BITS-1:0] diff;

    assign diff = (meas_share > ref_share) ? (meas_share - ref_share)
                                           : (ref_share - meas_share);

    always_ff @(posedge clk)
    begin
        sq_reg <= diff * diff;
    end

endmodule

`default_nettype wire

// ===== src/spectral_nearest_reference_classifier.sv =====
// ----------------------------------------------------------------------------
// spectral_nearest_reference_classifier
// nearest reference classifier on sum-normalized spectra
// ----------------------------------------------------------------------------
// A load item (cmd 0) normalizes its eight channels to Q0.16 shares of their
// sum and stores the shares, a nonzero-sum flag and the class code in one
// table row; it gives no result. A classify item (cmd 1) normalizes the
// measurement the same way, then, unless its sum is zero, walks entries 0 to
// ref_count-1 (saturated to MAX_REFS), one row per cycle, with eight distance
// lanes, an adder tree and a running minimum; it gives one result out.
// Normalization is eight restoring dividers run in parallel, one quotient bit
// a cycle; the search is set by the single read port of the table.
// Configuration is taken any time the block is idle; a result waiting on
// out_stall does not hold up taking the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_nearest_reference_classifier #(
    parameter int MAX_REFS    = scn_pkg::DEF_MAX_REFS,
    parameter int SAMPLE_BITS = scn_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,

    // configuration writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [scn_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [scn_pkg::CFG_DATA_BITS-1:0]     cfg_data,

    // input items
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  cmd,
    input  wire [scn_pkg::INDEX_BITS-1:0]        ref_index,
    input  wire [scn_pkg::CLASS_BITS-1:0]        ref_class,
    input  wire [SAMPLE_BITS-1:0]                chan_0,
    input  wire [SAMPLE_BITS-1:0]                chan_1,
    input  wire [SAMPLE_BITS-1:0]                chan_2,
    input  wire [SAMPLE_BITS-1:0]                chan_3,
    input  wire [SAMPLE_BITS-1:0]                chan_4,
    input  wire [SAMPLE_BITS-1:0]                chan_5,
    input  wire [SAMPLE_BITS-1:0]                chan_6,
    input  wire [SAMPLE_BITS-1:0]                chan_7,

    // result items
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [scn_pkg::CLASS_BITS-1:0]       class_code,
    output logic                                 unknown,
    output logic [scn_pkg::INDEX_BITS-1:0]       best_index
);

    localparam int NCH  = scn_pkg::NUM_CHANNELS;
    localparam int SB   = scn_pkg::SHARE_BITS;
    localparam int CB   = scn_pkg::CLASS_BITS;
    localparam int SW   = SAMPLE_BITS + $clog2(NCH);
    localparam int AW   = $clog2(MAX_REFS);
    localparam int CW   = $clog2(MAX_REFS + 1);
    localparam int DW   = 2*SB + $clog2(NCH);
    localparam int RW   = NCH*SB + 1 + CB;
    localparam int DCW  = $clog2(scn_pkg::DIV_STEPS);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_FIN    = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [scn_pkg::COUNT_BITS-1:0]  ref_count_reg;
    logic [scn_pkg::THRESH_BITS-1:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            thresh_reg    <= scn_pkg::THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scn_pkg::REG_REF_COUNT: ref_count_reg <= cfg_data[scn_pkg::COUNT_BITS-1:0];
                scn_pkg::REG_THRESHOLD: thresh_reg <= cfg_data[scn_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    logic [SAMPLE_BITS-1:0] chan_in [NCH];
    logic [SW-1:0]          sum_in;
    logic                   accept;

    assign chan_in[0] = chan_0;
    assign chan_in[1] = chan_1;
    assign chan_in[2] = chan_2;
    assign chan_in[3] = chan_3;
    assign chan_in[4] = chan_4;
    assign chan_in[5] = chan_5;
    assign chan_in[6] = chan_6;
    assign chan_in[7] = chan_7;

    always_comb
    begin
        sum_in = '0;
        for (int i = 0; i < NCH; i++)
        begin
            sum_in = sum_in + SW'(chan_in[i]);
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    logic                           cmd_reg;
    logic [scn_pkg::INDEX_BITS-1:0] idx_reg;
    logic [CB-1:0]                  cls_reg;
    logic [SW-1:0]                  sum_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            idx_reg <= ref_index;
            cls_reg <= ref_class;
            sum_reg <= sum_in;
        end
    end

    // normalization lanes
    logic [DCW-1:0] div_cnt_reg;
    logic [SB-1:0]  share [NCH];
    logic           div_step;

    assign div_step = (state_reg == ST_DIV);

    for (genvar g = 0; g < NCH; g++)
    begin : g_div
        scn_div_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .SUM_BITS    (SW)
        ) u_div (
            .clk      (clk),
            .start    (accept),
            .step     (div_step),
            .dividend (chan_in[g]),
            .divisor  (sum_reg),
            .share    (share[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (accept)
        begin
            div_cnt_reg <= '0;
        end
        else if (div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // reference table: shares, nonzero-sum flag, class
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    always_comb
    begin
        ram_wdata = '0;
        for (int i = 0; i < NCH; i++)
        begin
            ram_wdata[i*SB +: SB] = share[i];
        end
        ram_wdata[NCH*SB]           = (sum_reg != '0);
        ram_wdata[NCH*SB+1 +: CB]   = cls_reg;
    end

    // loads beyond the table are dropped
    assign ram_we = (state_reg == ST_FIN) && (cmd_reg == scn_pkg::CMD_LOAD)
                    && (32'(idx_reg) < MAX_REFS);

    scn_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_REFS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(idx_reg)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // search pipeline: read, lane squares, adder tree, running minimum
    logic [CW-1:0] issue_cnt_reg;
    logic [CW-1:0] limit_reg;
    logic          issuing;
    logic          v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic          nz2_reg, nz3_reg;
    logic [CB-1:0] cls2_reg, cls3_reg;
    logic [DW-1:0] dist3_reg;
    logic [DW-1:0] tree_sum;
    logic [2*SB-1:0] sq [NCH];

    logic          found_reg;
    logic [DW-1:0] best_dist_reg;
    logic [AW-1:0] best_idx_reg;
    logic [CB-1:0] best_cls_reg;

    assign issuing   = (state_reg == ST_SEARCH) && (issue_cnt_reg != limit_reg);
    assign ram_raddr = issue_cnt_reg[AW-1:0];

    for (genvar g = 0; g < NCH; g++)
    begin : g_dist
        scn_dist_lane u_dist (
            .clk        (clk),
            .meas_share (share[g]),
            .ref_share  (ram_rdata[g*SB +: SB]),
            .sq_reg     (sq[g])
        );
    end

    always_comb
    begin
        tree_sum = '0;
        for (int i = 0; i < NCH; i++)
        begin
            tree_sum = tree_sum + DW'(sq[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= issue_cnt_reg[AW-1:0];
        idx2_reg  <= idx1_reg;
        nz2_reg   <= ram_rdata[NCH*SB];
        cls2_reg  <= ram_rdata[NCH*SB+1 +: CB];
        idx3_reg  <= idx2_reg;
        nz3_reg   <= nz2_reg;
        cls3_reg  <= cls2_reg;
        dist3_reg <= tree_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            issue_cnt_reg <= '0;
            limit_reg     <= '0;
            found_reg     <= 1'b0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            best_cls_reg  <= '0;
        end
        else
        begin
            v1_reg <= issuing;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (state_reg == ST_FIN)
            begin
                issue_cnt_reg <= '0;
                limit_reg     <= (32'(ref_count_reg) > MAX_REFS) ? CW'(MAX_REFS)
                                                                 : CW'(ref_count_reg);
                found_reg     <= 1'b0;
                best_dist_reg <= '0;
                best_idx_reg  <= '0;
                best_cls_reg  <= '0;
            end
            else
            begin
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                // zero-sum entries skipped, strict compare keeps the first on a tie
                if (v3_reg && nz3_reg && (!found_reg || dist3_reg < best_dist_reg))
                begin
                    found_reg     <= 1'b1;
                    best_dist_reg <= dist3_reg;
                    best_idx_reg  <= idx3_reg;
                    best_cls_reg  <= cls3_reg;
                end
            end
        end
    end

    // result selection with black/white override
    logic [CB-1:0] win_cls;
    logic [CB-1:0] res_cls;
    logic          meas_zero;
    logic          out_load;

    assign meas_zero = (sum_reg == '0);

    always_comb
    begin
        win_cls = found_reg ? best_cls_reg : scn_pkg::CLASS_BLACK;
        res_cls = win_cls;
        if (win_cls == scn_pkg::CLASS_BLACK || win_cls == scn_pkg::CLASS_WHITE)
        begin
            res_cls = (32'(sum_reg) < 32'(thresh_reg)) ? scn_pkg::CLASS_BLACK
                                                       : scn_pkg::CLASS_WHITE;
        end
        if (meas_zero)
        begin
            res_cls = scn_pkg::CLASS_BLACK;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid || !out_stall);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            class_code <= res_cls;
            unknown    <= meas_zero;
            best_index <= meas_zero ? '0 : scn_pkg::INDEX_BITS'(best_idx_reg);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DCW'(scn_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (cmd_reg == scn_pkg::CMD_LOAD)
                begin
                    state_next = ST_IDLE;
                end
                else if (meas_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!issuing && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
